/* sv/bal_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the bounded array list.
package bal_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int ACTION_W = 2;
    localparam int POS_W    = 8;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int CMP_W    = ((POS_W > COUNT_W) ? POS_W : COUNT_W) + 1;

    localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_WRITE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ   = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // write address select
    localparam logic [1:0] WA_TAIL = 2'd0;
    localparam logic [1:0] WA_POS  = 2'd1;
    localparam logic [1:0] WA_IDX  = 2'd2;

    // read address select
    localparam logic [1:0] RA_POS       = 2'd0;
    localparam logic [1:0] RA_POS_NEXT  = 2'd1;
    localparam logic [1:0] RA_IDX_NEXT2 = 2'd2;

    // result value select
    localparam logic [1:0] RV_ZERO      = 2'd0;
    localparam logic [1:0] RV_MINUS_ONE = 2'd1;
    localparam logic [1:0] RV_RDATA     = 2'd2;

    typedef struct packed {
        logic                latch;
        logic                mem_we;
        logic [1:0]          wa_sel;
        logic                wd_shift;
        logic                rd_en;
        logic [1:0]          ra_sel;
        logic                idx_load;
        logic                idx_inc;
        logic                cnt_inc;
        logic                cnt_dec;
        logic                finish;
        logic [STATUS_W-1:0] res_status;
        logic [1:0]          rv_sel;
    } bal_cmd_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                full;
        logic                in_range;
        logic                pos_next_live;
        logic                idx_next_live;
    } bal_stat_t;

endpackage

/* sv/bounded_array_list.sv */
// Top level of the bounded array list: controller, datapath and checks.
//
// A request is taken when start is high and busy is low; busy then stays high until the
// request is finished, and its result beat shows on read_value, status and entries_now for
// exactly one cycle with done high. The receiver cannot stall it. Append, write and any
// out-of-range request finish in the decide state after the request is latched; a read
// also passes a read state for the memory fetch, and a remove with live entries above its
// position passes a shift state, in which the later entries of the entry memory are moved
// down one per cycle. A new request may be started in the cycle done is high.
module bounded_array_list
    import bal_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic        [ACTION_W-1:0] action,
    input  logic        [POS_W-1:0]    position,
    input  logic signed [VALUE_W-1:0]  value,
    output logic                       done,
    output logic signed [VALUE_W-1:0]  read_value,
    output logic        [STATUS_W-1:0] status,
    output logic        [COUNT_W-1:0]  entries_now
);

    bal_cmd_t  cmd;
    bal_stat_t stat;

    bal_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    bal_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .action      (action),
        .position    (position),
        .value       (value),
        .stat        (stat),
        .done        (done),
        .read_value  (read_value),
        .status      (status),
        .entries_now (entries_now)
    );

    // result beat only once the controller is back in idle
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done raised while busy");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entries_now <= COUNT_W'(CAPACITY))
        else $error("live count above capacity");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted request did not raise busy");

    a_full_only_at_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_FULL) |-> (entries_now == COUNT_W'(CAPACITY)))
        else $error("full reported below capacity");

endmodule

/* sv/bal_ctrl.sv */
// Controller state machine: sequences each request over the datapath.
module bal_ctrl
    import bal_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  bal_stat_t stat,
    output bal_cmd_t  cmd,
    output logic      busy
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECIDE = 2'd1;
    localparam logic [1:0] S_READ   = 2'd2;
    localparam logic [1:0] S_SHIFT  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (!stat.in_range && stat.action != ACT_APPEND)
                begin
                    cmd.finish     = 1'b1;
                    cmd.res_status = ST_RANGE;
                    cmd.rv_sel     = (stat.action == ACT_READ) ? RV_MINUS_ONE : RV_ZERO;
                    state_next     = S_IDLE;
                end
                else
                begin
                    unique case (stat.action)
                        ACT_APPEND:
                        begin
                            cmd.finish = 1'b1;
                            state_next = S_IDLE;
                            if (stat.full)
                            begin
                                cmd.res_status = ST_FULL;
                            end
                            else
                            begin
                                cmd.mem_we  = 1'b1;
                                cmd.wa_sel  = WA_TAIL;
                                cmd.cnt_inc = 1'b1;
                            end
                        end
                        ACT_WRITE:
                        begin
                            cmd.mem_we = 1'b1;
                            cmd.wa_sel = WA_POS;
                            cmd.finish = 1'b1;
                            state_next = S_IDLE;
                        end
                        ACT_READ:
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.ra_sel = RA_POS;
                            state_next = S_READ;
                        end
                        default:
                        begin
                            // remove: prime the shift with the entry above, or just drop the tail
                            if (stat.pos_next_live)
                            begin
                                cmd.rd_en    = 1'b1;
                                cmd.ra_sel   = RA_POS_NEXT;
                                cmd.idx_load = 1'b1;
                                state_next   = S_SHIFT;
                            end
                            else
                            begin
                                cmd.cnt_dec = 1'b1;
                                cmd.finish  = 1'b1;
                                state_next  = S_IDLE;
                            end
                        end
                    endcase
                end
            end
            S_READ:
            begin
                cmd.finish = 1'b1;
                cmd.rv_sel = RV_RDATA;
                state_next = S_IDLE;
            end
            default:
            begin
                // S_SHIFT: write the fetched word one place down, fetch the next
                cmd.mem_we   = 1'b1;
                cmd.wa_sel   = WA_IDX;
                cmd.wd_shift = 1'b1;
                if (stat.idx_next_live)
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.ra_sel  = RA_IDX_NEXT2;
                    cmd.idx_inc = 1'b1;
                end
                else
                begin
                    cmd.cnt_dec = 1'b1;
                    cmd.finish  = 1'b1;
                    state_next  = S_IDLE;
                end
            end
        endcase
    end

endmodule

/* sv/bal_datapath.sv */
// Datapath: request registers, entry memory, live count and result registers.
module bal_datapath
    import bal_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  bal_cmd_t                   cmd,
    input  logic        [ACTION_W-1:0] action,
    input  logic        [POS_W-1:0]    position,
    input  logic signed [VALUE_W-1:0]  value,
    output bal_stat_t                  stat,
    output logic                       done,
    output logic signed [VALUE_W-1:0]  read_value,
    output logic        [STATUS_W-1:0] status,
    output logic        [COUNT_W-1:0]  entries_now
);

    logic        [ACTION_W-1:0] action_reg;
    logic        [POS_W-1:0]    pos_reg;
    logic signed [VALUE_W-1:0]  val_reg;
    logic        [ADDR_W-1:0]   idx_reg;
    logic        [COUNT_W-1:0]  count_reg;
    logic signed [VALUE_W-1:0]  rdata_reg;
    logic signed [VALUE_W-1:0]  read_value_reg;
    logic        [STATUS_W-1:0] status_reg;
    logic                       done_reg;

    logic signed [VALUE_W-1:0]  mem [CAPACITY];

    logic        [ADDR_W-1:0]   pos_addr;
    logic        [ADDR_W-1:0]   wr_addr;
    logic        [ADDR_W-1:0]   rd_addr;
    logic signed [VALUE_W-1:0]  wr_data;
    logic signed [VALUE_W-1:0]  rv_next;
    logic        [CMP_W-1:0]    count_ext;

    // only used once the position is known to be below the count
    assign pos_addr  = pos_reg[ADDR_W-1:0];
    assign count_ext = CMP_W'(count_reg);

    assign stat.action        = action_reg;
    assign stat.full          = (count_reg == COUNT_W'(CAPACITY));
    assign stat.in_range      = (CMP_W'(pos_reg) < count_ext);
    assign stat.pos_next_live = ((CMP_W'(pos_reg) + CMP_W'(1)) < count_ext);
    assign stat.idx_next_live = ((CMP_W'(idx_reg) + CMP_W'(2)) < count_ext);

    always_comb
    begin
        case (cmd.wa_sel)
            WA_TAIL: wr_addr = count_reg[ADDR_W-1:0];
            WA_POS:  wr_addr = pos_addr;
            default: wr_addr = idx_reg;
        endcase
        case (cmd.ra_sel)
            RA_POS:      rd_addr = pos_addr;
            RA_POS_NEXT: rd_addr = pos_addr + ADDR_W'(1);
            default:     rd_addr = idx_reg + ADDR_W'(2);
        endcase
        case (cmd.rv_sel)
            RV_MINUS_ONE: rv_next = -VALUE_W'(1);
            RV_RDATA:     rv_next = rdata_reg;
            default:      rv_next = '0;
        endcase
        wr_data = cmd.wd_shift ? rdata_reg : val_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            action_reg <= action;
            pos_reg    <= position;
            val_reg    <= value;
        end
        if (cmd.idx_load)
        begin
            idx_reg <= pos_addr;
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_reg + ADDR_W'(1);
        end
        if (cmd.finish)
        begin
            read_value_reg <= rv_next;
            status_reg     <= cmd.res_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cmd.cnt_inc)
            begin
                count_reg <= count_reg + COUNT_W'(1);
            end
            else if (cmd.cnt_dec)
            begin
                count_reg <= count_reg - COUNT_W'(1);
            end
        end
    end

    assign done        = done_reg;
    assign read_value  = read_value_reg;
    assign status      = status_reg;
    assign entries_now = count_reg;

endmodule

/* bench/bounded_array_list_checker.sv */
// Checker for the bounded array list: shadow list, expected result queue and field compare.
`timescale 1ns / 100ps

module bounded_array_list_checker
    import bal_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  logic        [ACTION_W-1:0] action,
    input  logic        [POS_W-1:0]    position,
    input  logic signed [VALUE_W-1:0]  value,
    input  logic                       done,
    input  logic signed [VALUE_W-1:0]  read_value,
    input  logic        [STATUS_W-1:0] status,
    input  logic        [COUNT_W-1:0]  entries_now,
    output int                         fail_count,
    output int                         outstanding,
    output int                         list_length
);

    localparam logic signed [VALUE_W-1:0] MISS_WORD = -1;

    typedef struct packed {
        logic signed [VALUE_W-1:0] read_value;
        logic        [STATUS_W-1:0] status;
        logic        [COUNT_W-1:0]  entries_now;
    } outcome_t;

    logic signed [VALUE_W-1:0] entry_words [CAPACITY];
    int                        word_count = 0;
    outcome_t                  awaited_results [$];

    // Applies one request to the shadow list and returns the beat it should produce.
    function automatic outcome_t apply_request(
        input logic        [ACTION_W-1:0] act,
        input logic        [POS_W-1:0]    pos,
        input logic signed [VALUE_W-1:0]  val
    );
        outcome_t r;
        logic     fits;
        r.read_value = '0;
        r.status     = ST_OK;
        fits         = int'(pos) < word_count;
        if (act == ACT_APPEND)
        begin
            if (word_count >= CAPACITY)
                r.status = ST_FULL;
            else
            begin
                entry_words[word_count] = val;
                word_count++;
            end
        end
        else if (!fits)
        begin
            // position never used as an index here
            r.status = ST_RANGE;
            if (act == ACT_READ)
                r.read_value = MISS_WORD;
        end
        else
        begin
            case (act)
                ACT_WRITE: entry_words[pos] = val;
                ACT_READ:  r.read_value = entry_words[pos];
                default:
                begin
                    for (int i = int'(pos); i < word_count - 1; i++)
                        entry_words[i] = entry_words[i + 1];
                    word_count--;
                end
            endcase
        end
        r.entries_now = COUNT_W'(word_count);
        return r;
    endfunction

    always @(posedge clk)
    begin
        outcome_t exp;
        int       mismatches;
        mismatches = 0;
        if (!rst_n)
        begin
            awaited_results.delete();
            word_count = 0;
            fail_count <= 0;
        end
        else
        begin
            // retire the older beat first; a new request may be taken on the same edge
            if (done)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result beat with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    exp = awaited_results.pop_front();
                    if (read_value !== exp.read_value)
                    begin
                        $error("read_value: expected %0d, got %0d", exp.read_value, read_value);
                        mismatches++;
                    end
                    if (status !== exp.status)
                    begin
                        $error("status: expected %0d, got %0d", exp.status, status);
                        mismatches++;
                    end
                    if (entries_now !== exp.entries_now)
                    begin
                        $error("entries_now: expected %0d, got %0d",
                               exp.entries_now, entries_now);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
                awaited_results.push_back(apply_request(action, position, value));
            fail_count <= fail_count + mismatches;
        end
        outstanding <= awaited_results.size();
        list_length <= word_count;
    end

endmodule

/* bench/bounded_array_list_tb.sv */
// Testbench top for the bounded array list: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps

module bounded_array_list_tb;
    import bal_pkg::*;

    localparam int RANDOM_ITEMS = 750;

    typedef enum int { MIX_GROW, MIX_SHRINK, MIX_CHURN } mix_t;

    logic                       clk      = 1'b0;
    logic                       rst_n    = 1'b0;
    logic                       start    = 1'b0;
    logic        [ACTION_W-1:0] action   = ACT_APPEND;
    logic        [POS_W-1:0]    position = '0;
    logic signed [VALUE_W-1:0]  value    = '0;
    logic                       busy;
    logic                       done;
    logic signed [VALUE_W-1:0]  read_value;
    logic        [STATUS_W-1:0] status;
    logic        [COUNT_W-1:0]  entries_now;
    int                         fail_count;
    int                         outstanding;
    int                         list_length;

    bounded_array_list DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .position    (position),
        .value       (value),
        .done        (done),
        .read_value  (read_value),
        .status      (status),
        .entries_now (entries_now)
    );

    bounded_array_list_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .position    (position),
        .value       (value),
        .done        (done),
        .read_value  (read_value),
        .status      (status),
        .entries_now (entries_now),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .list_length (list_length)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Holds start high until the request is taken; start is left high for a following beat.
    task automatic issue(
        input logic        [ACTION_W-1:0] act,
        input logic        [POS_W-1:0]    pos,
        input logic signed [VALUE_W-1:0]  val
    );
        start    <= 1'b1;
        action   <= act;
        position <= pos;
        value    <= val;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Sender gap with junk on the fields, which must be ignored while start is low.
    task automatic hold_off(input int cycles);
        if (cycles > 0)
        begin
            start    <= 1'b0;
            action   <= ACTION_W'($urandom);
            position <= POS_W'($urandom);
            value    <= $urandom;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Waits until every outstanding beat has come back.
    task automatic settle();
        start <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    task automatic run_directed();
        // empty list: every positioned action is out of range
        issue(ACT_READ,   8'd0,   32'h1234_5678);
        issue(ACT_WRITE,  8'd0,   32'h7FFF_FFFF);
        issue(ACT_REMOVE, 8'd0,   32'h0);
        issue(ACT_READ,   8'd255, 32'h0);
        // appends with extreme words; position ignored
        issue(ACT_APPEND, 8'd255, 32'h8000_0000);
        issue(ACT_APPEND, 8'd0,   32'h7FFF_FFFF);
        issue(ACT_APPEND, 8'hAA,  32'hFFFF_FFFF);
        issue(ACT_APPEND, 8'h55,  32'h0);
        issue(ACT_READ,   8'd0,   32'hFFFF_FFFF);
        issue(ACT_READ,   8'd1,   32'h0);
        issue(ACT_READ,   8'd2,   32'h0);
        issue(ACT_READ,   8'd3,   32'hA5A5_A5A5);
        // position equal to the count and far above it
        issue(ACT_READ,   8'd4,   32'h0);
        issue(ACT_WRITE,  8'd4,   32'h1111_1111);
        issue(ACT_REMOVE, 8'd255, 32'h0);
        issue(ACT_WRITE,  8'd1,   32'h5555_5555);
        issue(ACT_READ,   8'd1,   32'h0);
        // remove from the middle, the tail and the head
        issue(ACT_REMOVE, 8'd1,   32'hFFFF_FFFF);
        issue(ACT_READ,   8'd1,   32'h0);
        issue(ACT_REMOVE, 8'd2,   32'h0);
        issue(ACT_READ,   8'd2,   32'h0);
        issue(ACT_REMOVE, 8'd0,   32'h0);
        issue(ACT_READ,   8'd0,   32'h0);
        settle();
    endtask

    task automatic run_random();
        int                  sent;
        int                  in_phase;
        int                  phase_len;
        int                  burst;
        int                  roll;
        int                  count;
        mix_t                mix;
        logic [ACTION_W-1:0] act;
        logic [POS_W-1:0]    pos;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            // the first phase fills the list and runs on into full appends
            if (sent == 0)
            begin
                mix       = MIX_GROW;
                phase_len = 110;
            end
            else
            begin
                mix       = mix_t'($urandom_range(2));
                phase_len = $urandom_range(20, 120);
            end
            in_phase = 0;
            while (in_phase < phase_len)
            begin
                burst = $urandom_range(1, 24);
                for (int k = 0; k < burst && in_phase < phase_len; k++)
                begin
                    count = list_length;
                    roll  = $urandom_range(99);
                    case (mix)
                        MIX_GROW:
                            act = (roll < 85) ? ACT_APPEND :
                                  (roll < 93) ? ACT_READ : ACT_WRITE;
                        MIX_SHRINK:
                            act = (roll < 70) ? ACT_REMOVE :
                                  (roll < 80) ? ACT_APPEND :
                                  (roll < 90) ? ACT_READ : ACT_WRITE;
                        default:
                            act = ACTION_W'($urandom_range(3));
                    endcase
                    // mostly live positions; the rest is noise over the whole field
                    if (count > 0 && act != ACT_APPEND && $urandom_range(99) < 88)
                        pos = POS_W'($urandom_range(count - 1));
                    else
                        pos = POS_W'($urandom_range(255));
                    issue(act, pos, $urandom);
                    in_phase++;
                    sent++;
                end
                if (in_phase < phase_len)
                    hold_off(($urandom_range(99) < 30) ? 0 : $urandom_range(1, 8));
            end
            settle();
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random();
        settle();
        repeat (CAPACITY + 4) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("bounded_array_list_tb passed");
        else
            $display("bounded_array_list_tb failed");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("bounded_array_list_tb failed");
        $finish;
    end

endmodule

/* sim.f */
sv/bal_pkg.sv
sv/bal_ctrl.sv
sv/bal_datapath.sv
sv/bounded_array_list.sv
bench/bounded_array_list_checker.sv
bench/bounded_array_list_tb.sv
